// ===== hw/rtl/ple_pkg.sv =====
// Shared codes, widths and control types for the positional list engine.
package ple_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 4;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT   = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_AT  = 3'd6;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_BOUNDS = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // Broadcast to every cell of the row for one beat.
  typedef struct packed {
    logic ins;   // open a slot at the target and write the new word
    logic del;   // close the slot at the target
    logic pick;  // drive the target cell's word onto the read bus
  } ple_ctrl_t;

endpackage

// ===== hw/rtl/positional_list_engine.sv =====
// Bounded ordered list of signed words held in a shifting row of cells.
// Every operation is applied in the cycle it is accepted: the cells from
// the target onward shift one place toward the tail on an insert or toward
// the head on a delete, and the result is registered on the output when
// the beat is accepted. One operation per cycle is sustained whenever the
// consumer takes each result; a held result stalls input only while it
// is not taken.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [POS_W-1:0]     in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ST_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic [CNT_OUT_W-1:0] out_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 out_valid_r;
  logic [ST_W-1:0]      status_r, status_nxt;
  logic [DATA_W-1:0]    result_r;
  logic [CNT_OUT_W-1:0] count_r;

  logic                 accept;
  logic                 full, empty;
  logic [XW-1:0]        cnt_x, pos_x, tgt;
  ple_ctrl_t            ctrl, ctrl_req;
  logic [DATA_W-1:0]    read_bus;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  logic [DATA_W-1:0] cell_val  [DEPTH];
  logic [DATA_W-1:0] cell_pick [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign cnt_x = XW'(cnt_r);
  assign pos_x = XW'(in_position);

  // Decode the operation into a target index and a checked action.
  always_comb begin
    tgt        = '0;
    ctrl_req   = '0;
    status_nxt = ST_OK;
    unique case (in_operation) inside
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
        if (in_operation == OP_INS_TAIL) begin
          tgt = cnt_x;
        end else if (in_operation == OP_INS_AT) begin
          tgt = pos_x;
        end
        if (full) begin
          status_nxt = ST_FULL;
        end else if (tgt > cnt_x) begin
          status_nxt = ST_BOUNDS;
        end else begin
          ctrl_req.ins = 1'b1;
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_AT, OP_READ_AT: begin
        if (in_operation == OP_DEL_TAIL) begin
          tgt = cnt_x - XW'(1);
        end else if (in_operation == OP_DEL_AT || in_operation == OP_READ_AT) begin
          tgt = pos_x;
        end
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (tgt >= cnt_x) begin
          status_nxt = ST_BOUNDS;
        end else begin
          ctrl_req.pick = 1'b1;
          ctrl_req.del  = (in_operation != OP_READ_AT);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Cells see no action unless the beat is taken.
  assign ctrl = accept ? ctrl_req : '0;

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (ctrl.del) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  assign cnt_ext = (CW + CNT_OUT_W)'(cnt_nxt);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_v, right_v;
    if (i == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_val[i+1];
    end
    ple_cell #(
      .XW (XW),
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .tgt      (tgt),
      .new_val  (in_value),
      .left_val (left_v),
      .right_val(right_v),
      .val      (cell_val[i]),
      .pick_val (cell_pick[i])
    );
  end

  // Only the target cell drives a nonzero word.
  always_comb begin
    read_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_bus = read_bus | cell_pick[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      result_r <= read_bus;
      count_r  <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_result_value = result_r;
  assign out_count        = count_r;

endmodule

// ===== hw/rtl/ple_cell.sv =====
// One list cell: holds a word and shifts toward either neighbor.
module ple_cell
  import ple_pkg::*;
#(
  parameter int XW  = 5,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  ple_ctrl_t         ctrl,
  input  logic [XW-1:0]     tgt,
  input  logic [DATA_W-1:0] new_val,
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  output logic [DATA_W-1:0] val,
  output logic [DATA_W-1:0] pick_val
);

  localparam logic [XW-1:0] IDX_X = XW'(IDX);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;
  logic              hit;

  assign hit = (IDX_X == tgt);

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (hit) begin
        val_nxt = new_val;
      end else if (IDX_X > tgt) begin
        val_nxt = left_val;
      end
    end else if (ctrl.del) begin
      if (IDX_X >= tgt) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val      = val_r;
  assign pick_val = (ctrl.pick && hit) ? val_r : '0;

endmodule

// ===== hw/rtl/ple_checker.sv =====
// Port-level checks for the positional list engine, bound to its top level.
module ple_checker
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ST_W-1:0]      out_status,
  input logic [DATA_W-1:0]    out_result_value,
  input logic [CNT_OUT_W-1:0] out_count
);

  localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(DEPTH);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_result_value) && $stable(out_count))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_value == '0)
    else $error("failed operation returned a nonzero word");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == FULL_CNT)
    else $error("full status with count below depth");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_count == '0)
    else $error("empty status with nonzero count");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

endmodule

bind positional_list_engine ple_checker #(
  .DEPTH(DEPTH)
) u_ple_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_result_value(out_result_value),
  .out_count       (out_count)
);
